>>> src/gcode_coordinate_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the G-code coordinate parser
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GCODE_COORDINATE_PARSER_ASSERT_SVH
`define GCODE_COORDINATE_PARSER_ASSERT_SVH

// cond must hold in the same cycle as trig
`define GCP_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// cond must hold in the cycle after trig
`define GCP_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

>>> src/gcp_pkg.sv
// ----------------------------------------------------------------------------
// gcp_pkg
// Shared types and constants of the G-code coordinate parser.
// ----------------------------------------------------------------------------
package gcp_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int OUT_COORD_W     = 16;

	localparam logic [7:0] CHAR_G    = 8'h47;
	localparam logic [7:0] CHAR_X    = 8'h58;
	localparam logic [7:0] CHAR_Y    = 8'h59;
	localparam logic [7:0] DIGIT_SET = 8'h30;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_file;
	} gcp_char_t;

	typedef struct packed {
		logic [3:0]             command_code;
		logic [OUT_COORD_W-1:0] x_coord;
		logic [OUT_COORD_W-1:0] y_coord;
	} gcp_rec_t;

endpackage

>>> src/gcode_coordinate_parser.sv
// ----------------------------------------------------------------------------
// gcode_coordinate_parser
// A record closed by an accepted byte is registered into the main entry, or into
// the skid entry while an older record is stalled. Throughput: one byte per cycle
// while char_stall is low; parse state updates in the accepting cycle. A two-entry
// output register (main + skid) lets bytes flow while a record waits; char_stall
// rises only when both entries are full. Reset clears parse state, command and accumulators; no records pending.
// ----------------------------------------------------------------------------
module gcode_coordinate_parser
	import gcp_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_stall,
	input  gcp_char_t char_data,
	output logic      rec_valid,
	input  logic      rec_stall,
	output gcp_rec_t  rec_data
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_X    = 2'd1;
	localparam logic [1:0] PH_Y    = 2'd2;

	logic [1:0]             phase_q, phase_n;
	logic                   take_q, take_n;
	logic [3:0]             cmd_q, cmd_n;
	logic [COORD_WIDTH-1:0] x_q, x_n;
	logic [COORD_WIDTH-1:0] y_q, y_n;
	logic [COORD_WIDTH-1:0] x_dig, y_dig;
	logic [COORD_WIDTH+OUT_COORD_W-1:0] x_ext, y_ext;
	logic                   emit;
	gcp_rec_t               rec_n;

	logic     accept, pop;
	logic     skid_valid_q;
	gcp_rec_t skid_q;
	gcp_rec_t main_q;
	logic     main_valid_q;

	assign accept = char_valid && !char_stall;
	assign pop    = main_valid_q && !rec_stall;

	// acc*10 + nibble as two shifts and adds, wrapped to COORD_WIDTH
	assign x_dig = (x_q << 3) + (x_q << 1)
		+ {{(COORD_WIDTH-4){1'b0}}, char_data.char_byte[3:0]};
	assign y_dig = (y_q << 3) + (y_q << 1)
		+ {{(COORD_WIDTH-4){1'b0}}, char_data.char_byte[3:0]};

	assign x_ext = {{OUT_COORD_W{1'b0}}, x_q};
	assign y_ext = {{OUT_COORD_W{1'b0}}, y_q};

	always_comb begin
		phase_n = phase_q;
		take_n  = take_q;
		cmd_n   = cmd_q;
		x_n     = x_q;
		y_n     = y_q;
		emit    = 1'b0;

		if (take_q) begin
			cmd_n  = char_data.char_byte[3:0];
			take_n = 1'b0;
		end

		case (phase_q)
			PH_X: begin
				if (char_data.char_byte == CHAR_Y) begin
					y_n     = '0;
					phase_n = PH_Y;
				end else begin
					x_n = x_dig;
				end
			end
			PH_Y: begin
				if ((char_data.char_byte & DIGIT_SET) != 8'h00) begin
					y_n = y_dig;
				end else begin
					emit    = 1'b1;
					phase_n = PH_IDLE;
				end
			end
			default: begin
				// unused code 3 behaves as idle
				phase_n = PH_IDLE;
				if (char_data.char_byte == CHAR_G) begin
					take_n = 1'b1;
				end else if (char_data.char_byte == CHAR_X) begin
					x_n     = '0;
					phase_n = PH_X;
				end
			end
		endcase

		rec_n.command_code = cmd_n;
		rec_n.x_coord      = x_ext[OUT_COORD_W-1:0];
		rec_n.y_coord      = y_ext[OUT_COORD_W-1:0];

		// end of file: drop any partial record
		if (char_data.end_of_file) begin
			phase_n = PH_IDLE;
			take_n  = 1'b0;
			cmd_n   = '0;
			x_n     = '0;
			y_n     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			take_q  <= 1'b0;
			cmd_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			take_q  <= take_n;
			cmd_q   <= cmd_n;
			x_q     <= x_n;
			y_q     <= y_n;
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept && emit) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (accept && emit) begin
			if (main_valid_q && !pop) begin
				skid_q <= rec_n;
			end else begin
				main_q <= rec_n;
			end
		end
	end

	assign char_stall = skid_valid_q;
	assign rec_valid  = main_valid_q;
	assign rec_data   = main_q;

endmodule

>>> src/gcp_checker.sv
// ----------------------------------------------------------------------------
// gcp_checker
// Port-level checks of the G-code coordinate parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "gcode_coordinate_parser_assert.svh"

module gcp_checker
	import gcp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      char_valid,
	input logic      char_stall,
	input logic      rec_valid,
	input logic      rec_stall,
	input gcp_rec_t  rec_data
);

	`GCP_ASSERT_NEXT(a_rec_hold, rec_valid && rec_stall, rec_valid, "record dropped while stalled")
	`GCP_ASSERT_NEXT(a_rec_stable, rec_valid && rec_stall, $stable(rec_data), "stalled record changed")
	// a new record only follows an accepted request
	`GCP_ASSERT_NOW(a_rec_cause, $rose(rec_valid), $past(char_valid && !char_stall), "record without request")
	// backpressure only when a record was already waiting
	`GCP_ASSERT_NOW(a_stall_cause, $rose(char_stall), $past(rec_valid && rec_stall), "stall without waiting record")

endmodule

bind gcode_coordinate_parser gcp_checker u_gcp_checker (.*);

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// G-code coordinate parser testbench
// Feeds ASCII and random bytes over the valid/stall channel. A scoreboard predicts each
// record from the accepted bytes, and each record taken from the output
// channel is checked field by field against the oldest prediction. Both
// channels idle at random, and one long receiver hold-off backs the parser up
// until it stalls its input.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gcp_pkg::*;

	localparam int          ACC_W           = COORD_WIDTH_DEF;
	localparam int          ITEM_TARGET     = 850;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT     = 400000;

	typedef enum logic [1:0] {PH_IDLE, PH_X, PH_Y} parse_phase_t;

	class gcode_record_scoreboard;
		parse_phase_t     phase;
		bit               take_command;
		logic [3:0]       command;
		logic [ACC_W-1:0] x_acc;
		logic [ACC_W-1:0] y_acc;
		gcp_rec_t         expected_records[$];
		int               failures;

		function new();
			clear_parse();
			failures = 0;
		endfunction

		function void clear_parse();
			phase        = PH_IDLE;
			take_command = 1'b0;
			command      = '0;
			x_acc        = '0;
			y_acc        = '0;
		endfunction

		function logic [ACC_W-1:0] add_digit(logic [ACC_W-1:0] acc, logic [7:0] b);
			return acc * ACC_W'(10) + ACC_W'(b[3:0]);
		endfunction

		function int pending();
			return expected_records.size();
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= 10) begin
				$display("%s", msg);
			end
		endfunction

		// Advance the parse state by one accepted byte.
		function void note_char(gcp_char_t c);
			gcp_rec_t   rec;
			logic [7:0] b;
			b = c.char_byte;
			if (take_command) begin
				command      = b[3:0];
				take_command = 1'b0;
			end
			case (phase)
				PH_X: begin
					if (b == CHAR_Y) begin
						y_acc = '0;
						phase = PH_Y;
					end else begin
						x_acc = add_digit(x_acc, b);
					end
				end
				PH_Y: begin
					if ((b & DIGIT_SET) != 8'h00) begin
						y_acc = add_digit(y_acc, b);
					end else begin
						rec.command_code = command;
						rec.x_coord      = OUT_COORD_W'(x_acc);
						rec.y_coord      = OUT_COORD_W'(y_acc);
						expected_records.push_back(rec);
						phase = PH_IDLE;
					end
				end
				default: begin
					phase = PH_IDLE;
					if (b == CHAR_G) begin
						take_command = 1'b1;
					end else if (b == CHAR_X) begin
						x_acc = '0;
						phase = PH_X;
					end
				end
			endcase
			// End of file drops any partial record.
			if (c.end_of_file) begin
				clear_parse();
			end
		endfunction

		function void check_record(gcp_rec_t got);
			gcp_rec_t want;
			if (expected_records.size() == 0) begin
				note_failure($sformatf("unexpected record: cmd=%h x=%h y=%h",
					got.command_code, got.x_coord, got.y_coord));
			end else begin
				want = expected_records.pop_front();
				if (got.command_code !== want.command_code || got.x_coord !== want.x_coord ||
				    got.y_coord !== want.y_coord) begin
					note_failure($sformatf(
						"record mismatch: expected cmd=%h x=%h y=%h, got cmd=%h x=%h y=%h",
						want.command_code, want.x_coord, want.y_coord,
						got.command_code, got.x_coord, got.y_coord));
				end
			end
		endfunction
	endclass

	bit          clk = 1'b0;
	logic        arst_n;
	logic        char_valid;
	logic        char_stall;
	gcp_char_t   char_data;
	logic        rec_valid;
	logic        rec_stall;
	gcp_rec_t    rec_data;

	gcode_record_scoreboard sb;
	bit          quiet;
	bit          hold_off_req;
	int          items_sent;
	int unsigned cycle_count;

	gcode_coordinate_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec_data   (rec_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		cycle_count = 0;
		wait (cycle_count >= CYCLE_LIMIT);
		$display("testbench: FAIL");
		$finish;
	end

	// Mostly short gaps, a few long ones, none during quiet stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_char(input logic [7:0] b, input logic eof);
		gcp_char_t c;
		int        gap;
		c.char_byte   = b;
		c.end_of_file = eof;
		gap = pick_gap();
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= c;
		// Hold the request until the parser takes it.
		do @(posedge clk); while (char_stall);
		sb.note_char(c);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input logic eof_on_last);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], eof_on_last && (i == s.len() - 1));
		end
	endtask

	// One well-formed record with random content, now and then cut by end of file.
	task automatic send_record();
		logic [7:0] b;
		int         n;
		if ($urandom_range(0, 2) != 0) begin
			send_char(CHAR_G, 1'b0);
			b = ($urandom_range(0, 9) < 7) ? 8'h30 + 8'($urandom_range(0, 9)) : 8'($urandom);
			send_char(b, 1'b0);
		end
		if ($urandom_range(0, 4) == 0) begin
			send_char(8'($urandom), 1'b0);
		end
		send_char(CHAR_X, 1'b0);
		n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(6, 12);
		repeat (n) begin
			b = ($urandom_range(0, 19) < 17) ? 8'h30 + 8'($urandom_range(0, 9)) : 8'($urandom);
			if (b == CHAR_Y) begin
				b = CHAR_X;
			end
			send_char(b, $urandom_range(0, 49) == 0);
		end
		send_char(CHAR_Y, $urandom_range(0, 49) == 0);
		n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(6, 12);
		repeat (n) begin
			if ($urandom_range(0, 19) < 17) begin
				b = 8'h30 + 8'($urandom_range(0, 9));
			end else begin
				b = 8'($urandom);
				if (b[5:4] == 2'b00) begin
					b[4] = 1'b1;
				end
			end
			send_char(b, $urandom_range(0, 49) == 0);
		end
		b = 8'($urandom);
		b[5:4] = 2'b00;
		send_char(b, $urandom_range(0, 9) == 0);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6)) begin
			send_char(8'($urandom), $urandom_range(0, 7) == 0);
		end
	endtask

	// Receiver: take records, stall at random, and serve hold-off requests.
	initial begin : record_sink
		int stall_left;
		bit next_stall;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rec_valid === 1'b1 && rec_stall === 1'b0) begin
				sb.check_record(rec_data);
			end
			@(negedge clk);
			if (hold_off_req) begin
				stall_left   = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			next_stall = (stall_left > 0);
			if (stall_left > 0) begin
				stall_left--;
			end
			rec_stall <= next_stall;
		end
	end

	initial begin
		sb           = new();
		quiet        = 1'b0;
		hold_off_req = 1'b0;
		items_sent   = 0;
		arst_n       = 1'b0;
		char_valid   = 1'b0;
		char_data    = '0;
		rec_stall    = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Command before any G.
		send_text("X1Y2\n", 1'b0);
		// Double G, then letters taken as X digits, full-byte Y digit, zero terminator.
		send_text("GGXGXY", 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b0);
		// Wrap both accumulators; the record closes on the end-of-file byte.
		send_text("X99999Y65536", 1'b0);
		send_char(8'h40, 1'b1);
		// End of file in the middle of a record.
		send_text("G5X34", 1'b1);

		// Back the parser up behind a long receiver hold-off.
		quiet        = 1'b1;
		hold_off_req = 1'b1;
		repeat (12) send_record();
		quiet = 1'b0;

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) < 8) begin
				send_record();
			end else begin
				send_noise();
			end
			if ($urandom_range(0, 9) == 0) begin
				quiet = !quiet;
			end
		end
		quiet = 1'b0;
		char_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule

>>> filelist.f
+incdir+src
src/gcp_pkg.sv
src/gcode_coordinate_parser.sv
src/gcp_checker.sv
verif/testbench.sv
